@@ src/efd_pkg.sv @@
// ----------------------------------------------------------------------------
// Escaped frame deframer package
// Register indexes, reset values, status codes and shared types.
// ----------------------------------------------------------------------------
package efd_pkg;

   // Widths of the link byte, the status code and the register index.
   localparam int unsigned ByteW  = 8;
   localparam int unsigned StatW  = 2;
   localparam int unsigned IndexW = 3;

   // Register indexes on the configuration port.
   localparam logic [IndexW-1:0] REG_START_CODE          = 3'd0;
   localparam logic [IndexW-1:0] REG_END_CODE            = 3'd1;
   localparam logic [IndexW-1:0] REG_ESCAPE_CODE         = 3'd2;
   localparam logic [IndexW-1:0] REG_ESCAPED_START_CODE  = 3'd3;
   localparam logic [IndexW-1:0] REG_ESCAPED_END_CODE    = 3'd4;
   localparam logic [IndexW-1:0] REG_ESCAPED_ESCAPE_CODE = 3'd5;

   // Reset values of the code registers.
   localparam logic [ByteW-1:0] RST_START_CODE          = 8'd141;
   localparam logic [ByteW-1:0] RST_END_CODE            = 8'd216;
   localparam logic [ByteW-1:0] RST_ESCAPE_CODE         = 8'd171;
   localparam logic [ByteW-1:0] RST_ESCAPED_START_CODE  = 8'd5;
   localparam logic [ByteW-1:0] RST_ESCAPED_END_CODE    = 8'd80;
   localparam logic [ByteW-1:0] RST_ESCAPED_ESCAPE_CODE = 8'd35;

   // Status of one result transfer.
   typedef enum logic [StatW-1:0] {
      STAT_DATA  = 2'd0,
      STAT_LAST  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_SHORT = 2'd3
   } status_type;

   // Fill level of the frame: nothing, start seen, one held, two held.
   typedef enum logic [1:0] {
      FILL_NONE  = 2'd0,
      FILL_START = 2'd1,
      FILL_ONE   = 2'd2,
      FILL_TWO   = 2'd3
   } fill_type;

   // The set of code registers.
   typedef struct packed {
      logic [ByteW-1:0] start_code;
      logic [ByteW-1:0] end_code;
      logic [ByteW-1:0] escape_code;
      logic [ByteW-1:0] escaped_start_code;
      logic [ByteW-1:0] escaped_end_code;
      logic [ByteW-1:0] escaped_escape_code;
   } codes_type;

   localparam codes_type RST_CODES = '{
      start_code:          RST_START_CODE,
      end_code:            RST_END_CODE,
      escape_code:         RST_ESCAPE_CODE,
      escaped_start_code:  RST_ESCAPED_START_CODE,
      escaped_end_code:    RST_ESCAPED_END_CODE,
      escaped_escape_code: RST_ESCAPED_ESCAPE_CODE
   };

   // Maps the byte after an escape; start beats end beats escape.
   function automatic logic [ByteW-1:0] map_escaped(input logic [ByteW-1:0] b,
                                                    input codes_type c);
      logic [ByteW-1:0] r;
      if (b == c.escaped_start_code) begin
         r = c.start_code;
      end else if (b == c.escaped_end_code) begin
         r = c.end_code;
      end else if (b == c.escaped_escape_code) begin
         r = c.escape_code;
      end else begin
         r = b;
      end
      return r;
   endfunction

endpackage

@@ src/escaped_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// Escaped frame deframer
// Removes escape bytes from a link byte stream, drops the start position and
// the checksum byte, and delivers the payload with the last byte marked.
// ----------------------------------------------------------------------------
// A result is registered and appears in the cycle after the transfer of the
// byte that causes it; payload bytes trail the link by two unescaped bytes.
// Throughput: one byte per cycle, set by the single result register, which
// accepts a new byte whenever it is empty or being emptied, not while stalled.
// Reset: synchronous; clears the frame state and output valid and restores
// the default codes. The two held bytes are not reset.
module escaped_frame_deframer (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration write port
   input  logic                              csr_we,
   input  logic [efd_pkg::IndexW-1:0]        csr_index,
   input  logic [efd_pkg::ByteW-1:0]         csr_wdata,
   // Link byte stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [efd_pkg::ByteW-1:0]         req_tdata,   // [7:0] rx_byte
   // Payload stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [efd_pkg::ByteW-1:0]         rsp_tdata,   // [7:0] payload_byte
   output logic [efd_pkg::StatW-1:0]         rsp_tuser    // [1:0] frame_status
);
   import efd_pkg::*;

   codes_type        codes_ff, codes_in;
   logic             escape_pending_ff, escape_pending_in;
   fill_type         fill_ff, fill_in;
   logic [ByteW-1:0] held_older_ff, held_older_in;
   logic [ByteW-1:0] held_newer_ff, held_newer_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ByteW-1:0] rsp_data_ff, rsp_data_in;
   status_type       rsp_status_ff, rsp_status_in;

   logic             accept;
   logic             emit;
   logic [ByteW-1:0] data;

   // A byte is taken whenever the result register is free or being emptied.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Configuration writes; unknown indexes are ignored.
   always_comb begin
      codes_in = codes_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_START_CODE:          codes_in.start_code          = csr_wdata;
            REG_END_CODE:            codes_in.end_code            = csr_wdata;
            REG_ESCAPE_CODE:         codes_in.escape_code         = csr_wdata;
            REG_ESCAPED_START_CODE:  codes_in.escaped_start_code  = csr_wdata;
            REG_ESCAPED_END_CODE:    codes_in.escaped_end_code    = csr_wdata;
            REG_ESCAPED_ESCAPE_CODE: codes_in.escaped_escape_code = csr_wdata;
            default: ;
         endcase
      end
   end

   // Frame decoding for one transferred byte.
   always_comb begin
      escape_pending_in = escape_pending_ff;
      fill_in           = fill_ff;
      held_older_in     = held_older_ff;
      held_newer_in     = held_newer_ff;
      emit              = 1'b0;
      rsp_data_in       = rsp_data_ff;
      rsp_status_in     = rsp_status_ff;
      data              = escape_pending_ff ? map_escaped(req_tdata, codes_ff) : req_tdata;
      if (accept) begin
         priority if (req_tdata == codes_ff.end_code) begin
            // The end code closes the frame, even after an escape.
            emit              = 1'b1;
            escape_pending_in = 1'b0;
            fill_in           = FILL_NONE;
            unique case (fill_ff)
               FILL_TWO: begin
                  rsp_data_in   = held_older_ff;
                  rsp_status_in = STAT_LAST;
               end
               FILL_ONE: begin
                  rsp_data_in   = '0;
                  rsp_status_in = STAT_EMPTY;
               end
               default: begin
                  rsp_data_in   = '0;
                  rsp_status_in = STAT_SHORT;
               end
            endcase
         end else if (!escape_pending_ff && req_tdata == codes_ff.escape_code) begin
            // The escape byte itself is dropped.
            escape_pending_in = 1'b1;
         end else begin
            // An unescaped byte moves through the two-byte hold line.
            escape_pending_in = 1'b0;
            unique case (fill_ff)
               FILL_NONE: begin
                  fill_in = FILL_START;
               end
               FILL_START: begin
                  held_newer_in = data;
                  fill_in       = FILL_ONE;
               end
               FILL_ONE: begin
                  held_older_in = held_newer_ff;
                  held_newer_in = data;
                  fill_in       = FILL_TWO;
               end
               default: begin
                  emit          = 1'b1;
                  rsp_data_in   = held_older_ff;
                  rsp_status_in = STAT_DATA;
                  held_older_in = held_newer_ff;
                  held_newer_in = data;
               end
            endcase
         end
      end
   end

   // The result register holds until the transfer completes.
   assign rsp_valid_in = accept ? emit : (rsp_valid_ff && !rsp_tready);

   // Control state and code registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff          <= RST_CODES;
         escape_pending_ff <= 1'b0;
         fill_ff           <= FILL_NONE;
         rsp_valid_ff      <= 1'b0;
      end else begin
         codes_ff          <= codes_in;
         escape_pending_ff <= escape_pending_in;
         fill_ff           <= fill_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      held_older_ff <= held_older_in;
      held_newer_ff <= held_newer_in;
      if (accept && emit) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef ASSERT_OFF
   // A stalled result blocks the link side.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("byte taken while a result is stalled");

   // Empty and short statuses carry a zero byte.
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STAT_EMPTY || rsp_status_ff == STAT_SHORT))
      |-> (rsp_data_ff == '0))
      else $error("non-zero byte with empty or short status");

   // An end code clears the frame state and always yields a result.
   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tdata == codes_ff.end_code)
      |=> (fill_ff == FILL_NONE && !escape_pending_ff && rsp_valid_ff))
      else $error("end code did not close the frame");

   // Payload data only comes out once two bytes are held.
   a_data_needs_fill: assert property (@(posedge clock) disable iff (reset)
      (accept && emit && rsp_status_in == STAT_DATA) |-> (fill_ff == FILL_TWO))
      else $error("data byte emitted before the hold line was full");
`endif

endmodule
